// File: design/merl_pkg.sv
// ----------------------------------------------------------------------------
// merl_pkg: shared types and constants for the motor effort ramp limiter
// Register map, reset values and the configuration bundle seen by the lanes.
// ----------------------------------------------------------------------------
package merl_pkg;

    localparam int EFFORT_W = 8;          // applied effort, signed
    localparam int LANE_W   = 9;          // effort before clamping, signed
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
    localparam logic [2:0] REG_TURN_LIMIT  = 3'd1;
    localparam logic [2:0] REG_RAMP_ZONE   = 3'd2;
    localparam logic [2:0] REG_RAMP_STEP   = 3'd3;
    localparam logic [2:0] REG_DEAD_BAND   = 3'd4;

    localparam logic [6:0] SPEED_LIMIT_RST = 7'd25;
    localparam logic [6:0] TURN_LIMIT_RST  = 7'd35;
    localparam logic [6:0] RAMP_ZONE_RST   = 7'd15;
    localparam logic [4:0] RAMP_STEP_RST   = 5'd5;
    localparam logic [3:0] DEAD_BAND_RST   = 4'd1;

    // 205 / 1024 gives floor(m / 5) exactly for m below 1024
    localparam logic [7:0] FIFTH_RECIP    = 8'd205;

    typedef struct packed {
        logic [6:0] speed_limit;
        logic [6:0] turn_limit;
        logic [6:0] ramp_zone;
        logic [4:0] ramp_step;
        logic [3:0] dead_band;
    } cfg_t;

endpackage

// File: design/motor_effort_ramp_limiter.sv
// ----------------------------------------------------------------------------
// motor_effort_ramp_limiter: per-tick ramp and clamp of three motor efforts
// Each taken request with s_tuser low puts its result into the output queue.
// Throughput: one request per cycle; a two-entry output queue holds results
// while m_tready is low, s_tready drops only when both entries are full.
// Reset (aresetn low, synchronous): efforts go to zero, registers to defaults,
// the output queue empties.
// ----------------------------------------------------------------------------
module motor_effort_ramp_limiter (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] left_demand, [15:8] right_demand,
                                    // [23:16] flipper_demand
    input  logic        s_tuser,    // arm_active

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] left_effort, [15:8] right_effort,
                                    // [23:16] flipper_effort

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [merl_pkg::ADDR_W-1:0] paddr,
    input  logic [merl_pkg::DATA_W-1:0] pwdata,
    output logic [merl_pkg::DATA_W-1:0] prdata,
    output logic        pready
);

    merl_pkg::cfg_t cfg_reg;

    logic [7:0] left_eff_reg;
    logic [7:0] right_eff_reg;
    logic [7:0] flipper_eff_reg;

    logic [8:0] left_lane;
    logic [8:0] right_lane;
    logic [8:0] flipper_lane;
    logic [7:0] left_new;
    logic [7:0] right_new;
    logic [7:0] flipper_new;

    logic [23:0] queue_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    logic        in_take;
    logic        push;
    logic        pop;
    logic        cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_limit <= merl_pkg::SPEED_LIMIT_RST;
            cfg_reg.turn_limit  <= merl_pkg::TURN_LIMIT_RST;
            cfg_reg.ramp_zone   <= merl_pkg::RAMP_ZONE_RST;
            cfg_reg.ramp_step   <= merl_pkg::RAMP_STEP_RST;
            cfg_reg.dead_band   <= merl_pkg::DEAD_BAND_RST;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                merl_pkg::REG_SPEED_LIMIT: cfg_reg.speed_limit <= pwdata[6:0];
                merl_pkg::REG_TURN_LIMIT:  cfg_reg.turn_limit  <= pwdata[6:0];
                merl_pkg::REG_RAMP_ZONE:   cfg_reg.ramp_zone   <= pwdata[6:0];
                merl_pkg::REG_RAMP_STEP:   cfg_reg.ramp_step   <= pwdata[4:0];
                merl_pkg::REG_DEAD_BAND:   cfg_reg.dead_band   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            merl_pkg::REG_SPEED_LIMIT: prdata = {25'd0, cfg_reg.speed_limit};
            merl_pkg::REG_TURN_LIMIT:  prdata = {25'd0, cfg_reg.turn_limit};
            merl_pkg::REG_RAMP_ZONE:   prdata = {25'd0, cfg_reg.ramp_zone};
            merl_pkg::REG_RAMP_STEP:   prdata = {27'd0, cfg_reg.ramp_step};
            merl_pkg::REG_DEAD_BAND:   prdata = {28'd0, cfg_reg.dead_band};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- lanes and merge ----------------
    merl_lane u_lane_left (
        .cfg         (cfg_reg),
        .ramp_en     (1'b1),
        .demand      (s_tdata[7:0]),
        .effort      (left_eff_reg),
        .next_effort (left_lane)
    );

    merl_lane u_lane_right (
        .cfg         (cfg_reg),
        .ramp_en     (1'b1),
        .demand      (s_tdata[15:8]),
        .effort      (right_eff_reg),
        .next_effort (right_lane)
    );

    merl_lane u_lane_flipper (
        .cfg         (cfg_reg),
        .ramp_en     (1'b0),
        .demand      (s_tdata[23:16]),
        .effort      (flipper_eff_reg),
        .next_effort (flipper_lane)
    );

    merl_merge u_merge (
        .cfg         (cfg_reg),
        .left_in     (left_lane),
        .right_in    (right_lane),
        .flipper_in  (flipper_lane),
        .left_out    (left_new),
        .right_out   (right_new),
        .flipper_out (flipper_new)
    );

    // ---------------- handshake and state ----------------
    assign s_tready = (count_reg != 2'd2);
    assign in_take  = s_tvalid && s_tready;
    assign push     = in_take && !s_tuser;     // armed ticks leave no trace
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_eff_reg    <= 8'd0;
            right_eff_reg   <= 8'd0;
            flipper_eff_reg <= 8'd0;
        end else if (push) begin
            left_eff_reg    <= left_new;
            right_eff_reg   <= right_new;
            flipper_eff_reg <= flipper_new;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= {flipper_new, right_new, left_new};
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = queue_reg[rd_ptr_reg];

endmodule

// File: design/merl_lane.sv
// ----------------------------------------------------------------------------
// merl_lane: per-motor effort update
// Deadband on the demand, then a fixed ramp step near zero (drive motors, zero
// demand gives zero) or a fifth of the error, result truncated toward zero.
// ----------------------------------------------------------------------------
module merl_lane (
    input  merl_pkg::cfg_t                  cfg,
    input  logic                            ramp_en,   // drive motor: ramp zone applies
    input  logic [merl_pkg::EFFORT_W-1:0]   demand,
    input  logic [merl_pkg::EFFORT_W-1:0]   effort,
    output logic [merl_pkg::LANE_W-1:0]     next_effort
);

    logic [7:0]  dmag;
    logic [7:0]  want;
    logic [8:0]  err;
    logic        err_pos;
    logic        err_neg;
    logic [7:0]  emag;
    logic        in_zone;
    logic [8:0]  eff9;
    logic [8:0]  step9;
    logic [8:0]  ramp_val;
    logic [10:0] sum;
    logic [9:0]  smag;
    logic [17:0] prod;
    logic [7:0]  quot;
    logic [8:0]  fifth_val;

    always_comb begin
        dmag = demand[7] ? (8'd0 - demand) : demand;
        want = (dmag <= {4'b0, cfg.dead_band}) ? 8'd0 : demand;

        err     = {want[7], want} - {effort[7], effort};
        err_pos = !err[8] && (err != 9'd0);
        err_neg = err[8];

        emag    = effort[7] ? (8'd0 - effort) : effort;
        in_zone = emag <= {1'b0, cfg.ramp_zone};

        eff9  = {effort[7], effort};
        step9 = {4'b0, cfg.ramp_step};
        if (err_pos && !want[7] && (want != 8'd0)) begin
            ramp_val = eff9 + step9;
        end else if (err_neg && want[7]) begin
            ramp_val = eff9 - step9;
        end else if (want == 8'd0) begin
            ramp_val = 9'd0;
        end else begin
            ramp_val = eff9;
        end

        // (5*effort + err) = 4*effort + want
        sum       = {effort[7], effort, 2'b00} + {{3{want[7]}}, want};
        smag      = sum[10] ? 10'(11'd0 - sum) : sum[9:0];
        prod      = smag * merl_pkg::FIFTH_RECIP;
        quot      = prod[17:10];
        fifth_val = sum[10] ? (9'd0 - {1'b0, quot}) : {1'b0, quot};

        next_effort = (ramp_en && in_zone) ? ramp_val : fifth_val;
    end

endmodule

// File: design/merl_merge.sv
// ----------------------------------------------------------------------------
// merl_merge: combine the three lane results
// Opposite-sign drive efforts clamp to the turn limit, then every effort
// clamps to the speed limit.
// ----------------------------------------------------------------------------
module merl_merge (
    input  merl_pkg::cfg_t                  cfg,
    input  logic [merl_pkg::LANE_W-1:0]     left_in,
    input  logic [merl_pkg::LANE_W-1:0]     right_in,
    input  logic [merl_pkg::LANE_W-1:0]     flipper_in,
    output logic [merl_pkg::EFFORT_W-1:0]   left_out,
    output logic [merl_pkg::EFFORT_W-1:0]   right_out,
    output logic [merl_pkg::EFFORT_W-1:0]   flipper_out
);

    function automatic logic [8:0] clamp_sym(input logic [8:0] v, input logic [6:0] lim);
        logic [8:0] hi;
        logic [8:0] lo;
        hi = {2'b00, lim};
        lo = 9'd0 - hi;
        if ($signed(v) > $signed(hi)) begin
            clamp_sym = hi;
        end else if ($signed(v) < $signed(lo)) begin
            clamp_sym = lo;
        end else begin
            clamp_sym = v;
        end
    endfunction

    logic       l_pos, l_neg, r_pos, r_neg;
    logic       opposite;
    logic [8:0] left_t;
    logic [8:0] right_t;
    logic [8:0] left_c;
    logic [8:0] right_c;
    logic [8:0] flipper_c;

    always_comb begin
        l_pos = !left_in[8] && (left_in != 9'd0);
        l_neg = left_in[8];
        r_pos = !right_in[8] && (right_in != 9'd0);
        r_neg = right_in[8];
        opposite = (l_pos && r_neg) || (l_neg && r_pos);

        left_t  = opposite ? clamp_sym(left_in, cfg.turn_limit) : left_in;
        right_t = opposite ? clamp_sym(right_in, cfg.turn_limit) : right_in;

        left_c    = clamp_sym(left_t, cfg.speed_limit);
        right_c   = clamp_sym(right_t, cfg.speed_limit);
        flipper_c = clamp_sym(flipper_in, cfg.speed_limit);

        left_out    = left_c[7:0];
        right_out   = right_c[7:0];
        flipper_out = flipper_c[7:0];
    end

endmodule
